>>> hw/rtl/pse_pkg.sv
// Shared types and constants of the postfix stack evaluator.
// No dependencies; the top level, pse_alu, pse_checker and the testbench refer to this package by scope.
`default_nettype none

package pse_pkg;

  localparam int StackDepth = 64;   // default operand stack size
  localparam int DataW      = 32;   // operand and result width
  localparam int DepthW     = 7;    // width of the reported stack depth
  localparam int StatusW    = 3;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_OPERATE = 2'd1,
    KIND_FINISH  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_FULL  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_FINAL = 3'd4
  } status_e;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/postfix_stack_evaluator.sv
// Top level of the postfix (RPN) integer expression evaluator.
// Uses pse_pkg, pse_ram (operand stack) and pse_alu (shared arithmetic unit).
`default_nettype none

// The block takes one transfer at a time on the input stream and returns one
// result transfer for each. tuser selects push, operate or finish. Push, finish,
// the unused kind and the too-few-operands error answer directly (result
// valid the cycle after the input transfer). An operate reads the
// second-from-top entry from the stack RAM into S_READ; a zero divisor is
// caught there and answers from S_READ. Otherwise the shared unit runs in
// S_CALC: add and subtract use its adder once, multiply and divide take 32
// iterations of the shared adder, and the result is loaded when the unit
// reports done. A new item is taken in the cycle its predecessor's result is
// taken, so the block never takes a new item while one is still processed. The
// top of stack is kept in a register, so only one RAM read per operate is
// needed. Input is refused while an operation runs and while an undelivered
// result sits in the output register; the input is taken in the same cycle
// the held result is taken. Errors leave the stack as it was. The stack RAM
// is not cleared; only entries below the count are ever read.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::StackDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [31:0] s_tdata_i,   // [31:0] operand_value
  input  wire logic [3:0]  s_tuser_i,   // [1:0] kind, [3:2] op_code
  // result stream
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [39:0] m_tdata_o,   // [31:0] top_value, [38:32] stack_depth, [39] zero
  output logic      [2:0]  m_tuser_o    // [2:0] status
);

  localparam int W  = pse_pkg::DataW;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = pse_pkg::DepthW;

  typedef enum logic [1:0] {
    S_IDLE,   // waiting for an input transfer
    S_READ,   // second operand arriving from RAM
    S_CALC    // shared unit busy
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;       // number of stored values
  logic [W-1:0]    top_q, top_d;       // copy of the top entry
  pse_pkg::op_e    op_q;

  logic                       out_valid_q;
  pse_pkg::status_e           out_status_q;
  logic [W-1:0]               out_top_q;
  logic [DW-1:0]              out_depth_q;

  // input fields
  logic          in_accept;
  logic [1:0]    in_kind;
  logic [1:0]    in_op;
  logic [W-1:0]  in_val;

  // result load
  logic              ld;
  pse_pkg::status_e  ld_status;
  logic [W-1:0]      ld_top;
  logic              ld_keep_top;      // successful finish reports a value at depth 0
  logic [CW+DW-1:0]  depth_ext;

  // RAM and unit hookup
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [W-1:0]    ram_wdata, ram_rdata;
  logic [CW-1:0]   cnt_m2;
  pse_pkg::alu_req_t alu_req;
  logic            alu_done;
  logic [W-1:0]    alu_res;

  assign in_kind   = s_tuser_i[1:0];
  assign in_op     = s_tuser_i[3:2];
  assign in_val    = s_tdata_i;
  assign s_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_tready_i);
  assign in_accept = s_tvalid_i && s_tready_o;
  assign cnt_m2    = cnt_q - CW'(2);
  assign ram_raddr = cnt_m2[AW-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    top_d       = top_q;
    ld          = 1'b0;
    ld_status   = pse_pkg::ST_OK;
    ld_top      = top_q;
    ld_keep_top = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = cnt_q[AW-1:0];
    ram_wdata   = in_val;
    alu_req     = '{start: 1'b0, op: op_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (in_kind)
            pse_pkg::KIND_PUSH: begin
              ld = 1'b1;
              if (cnt_q >= CW'(STACK_DEPTH)) begin
                ld_status = pse_pkg::ST_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                top_d  = in_val;
                ld_top = in_val;
              end
            end
            pse_pkg::KIND_OPERATE: begin
              if (cnt_q < CW'(2)) begin
                ld        = 1'b1;
                ld_status = pse_pkg::ST_FEW;
              end else begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end
            end
            pse_pkg::KIND_FINISH: begin
              ld = 1'b1;
              if (cnt_q != CW'(1)) begin
                ld_status = pse_pkg::ST_FINAL;
              end else begin
                cnt_d       = '0;
                ld_keep_top = 1'b1;
              end
            end
            default: ld = 1'b1;   // unused kind: report current state
          endcase
        end
      end
      S_READ: begin
        // ram_rdata is second-from-top, top_q is top
        if (op_q == pse_pkg::OP_DIV && top_q == '0) begin
          ld        = 1'b1;
          ld_status = pse_pkg::ST_DIVZ;
          state_d   = S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        if (alu_done) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[AW-1:0];
          ram_wdata = alu_res;
          cnt_d     = cnt_q - 1'b1;
          top_d     = alu_res;
          ld        = 1'b1;
          ld_top    = alu_res;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign depth_ext = {{DW{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= ld || (out_valid_q && !m_tready_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_accept) begin
      op_q <= pse_pkg::op_e'(in_op);
    end
    if (ld) begin
      out_status_q <= ld_status;
      out_top_q    <= (ld_keep_top || cnt_d != '0) ? ld_top : '0;
      out_depth_q  <= depth_ext[DW-1:0];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {1'b0, out_depth_q, out_top_q};
  assign m_tuser_o  = out_status_q;

  pse_ram #(
    .WIDTH(W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  pse_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .a_i     (ram_rdata),
    .b_i     (top_q),
    .done_o  (alu_done),
    .result_o(alu_res)
  );

endmodule

`default_nettype wire

>>> hw/rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pse_alu.sv
// Shared arithmetic unit: one 33-bit adder, used once for add/subtract and
// 32 times for shift-add multiply and restoring divide. Uses pse_pkg.
`default_nettype none

module pse_alu (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pse_pkg::alu_req_t            req_i,
  input  wire logic [pse_pkg::DataW-1:0]    a_i,
  input  wire logic [pse_pkg::DataW-1:0]    b_i,
  output logic                              done_o,
  output logic      [pse_pkg::DataW-1:0]    result_o
);

  localparam int W = pse_pkg::DataW;

  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV
  } astate_e;

  astate_e                 state_q;
  logic [$clog2(W)-1:0]    step_q;
  logic [W-1:0]            acc_q;   // product accumulator / partial remainder
  logic [W-1:0]            mq_q;    // multiplier / dividend-quotient shift
  logic [W-1:0]            mc_q;    // multiplicand / divisor magnitude
  logic                    neg_q;

  logic [W:0] add_x, add_y, sum;
  logic       add_sub;
  logic       qbit;
  logic [W-1:0] rem_next, q_next;
  logic [W-1:0] a_mag, b_mag;

  // the one shared adder
  always_comb begin
    add_x   = {1'b0, a_i};
    add_y   = {1'b0, b_i};
    add_sub = (req_i.op == pse_pkg::OP_SUB);
    unique case (state_q)
      A_MUL: begin
        add_x   = {1'b0, acc_q};
        add_y   = mq_q[0] ? {1'b0, mc_q} : '0;
        add_sub = 1'b0;
      end
      A_DIV: begin
        add_x   = {acc_q, mq_q[W-1]};
        add_y   = {1'b0, mc_q};
        add_sub = 1'b1;
      end
      default: ;
    endcase
    sum = add_x + (add_sub ? ~add_y : add_y) + {{W{1'b0}}, add_sub};
  end

  // restoring step: no borrow means the divisor fits
  assign qbit     = ~sum[W];
  assign rem_next = qbit ? sum[W-1:0] : add_x[W-1:0];
  assign q_next   = {mq_q[W-2:0], qbit};

  assign a_mag = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_mag = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_o  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            step_q <= '0;
            case (req_i.op)
              pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
                result_o <= sum[W-1:0];
                done_o   <= 1'b1;
              end
              pse_pkg::OP_MUL: begin
                acc_q   <= '0;
                mq_q    <= b_i;
                mc_q    <= a_i;
                state_q <= A_MUL;
              end
              default: begin
                acc_q   <= '0;
                mq_q    <= a_mag;
                mc_q    <= b_mag;
                neg_q   <= a_i[W-1] ^ b_i[W-1];
                state_q <= A_DIV;
              end
            endcase
          end
        end
        A_MUL: begin
          acc_q  <= sum[W-1:0];
          mq_q   <= mq_q >> 1;
          mc_q   <= mc_q << 1;
          step_q <= step_q + 1'b1;
          if (step_q == '1) begin
            result_o <= sum[W-1:0];
            done_o   <= 1'b1;
            state_q  <= A_IDLE;
          end
        end
        A_DIV: begin
          acc_q  <= rem_next;
          mq_q   <= q_next;
          step_q <= step_q + 1'b1;
          if (step_q == '1) begin
            result_o <= neg_q ? (~q_next + W'(1)) : q_next;
            done_o   <= 1'b1;
            state_q  <= A_IDLE;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/pse_checker.sv
// Port-level checks for the postfix stack evaluator, attached by bind.
// Uses pse_pkg; binds to postfix_stack_evaluator.
`default_nettype none

module pse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_tvalid_i,
  input wire logic        s_tready_o,
  input wire logic        m_tvalid_o,
  input wire logic        m_tready_i,
  input wire logic [39:0] m_tdata_o,
  input wire logic [2:0]  m_tuser_o
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  // no input is taken while an untaken result would be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |-> !s_tready_o)
    else $error("input ready while result held");

  // after an input transfer either a result shows or the block is busy
  a_result_or_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o |=> m_tvalid_o || !s_tready_o)
    else $error("input transfer lost");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tuser_o <= 3'(pse_pkg::ST_FINAL))
    else $error("undefined status code");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tvalid_i(s_tvalid_i),
  .s_tready_o(s_tready_o),
  .m_tvalid_o(m_tvalid_o),
  .m_tready_i(m_tready_i),
  .m_tdata_o (m_tdata_o),
  .m_tuser_o (m_tuser_o)
);

`default_nettype wire

>>> dv/postfix_stack_evaluator_test.sv
// Self-checking testbench of postfix_stack_evaluator: directed corner cases,
// random postfix expressions and noise, checked against an in-bench stack predictor.
// Depends on pse_pkg and the postfix_stack_evaluator RTL.
`timescale 1ns / 1ps

module postfix_stack_evaluator_test;

  localparam int          Depth      = pse_pkg::StackDepth;
  localparam logic [1:0]  KindUnused = 2'd3;      // fourth tuser kind, no meaning
  localparam int          ItemsRandom = 340;      // random part ends here
  localparam int          ItemsTotal  = 400;      // back-to-back tail ends here
  localparam int          LongHold    = 300;      // receiver hold-off, cycles
  localparam int          TailCycles  = 80;       // quiet wait after the last result
  localparam time         RunLimit    = 5ms;

  // One expected result transfer.
  typedef struct {
    pse_pkg::status_e status;
    logic [31:0]      top;
    logic [6:0]       depth;
  } stack_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [31:0] s_tdata_i;     // [31:0] operand_value
  logic [3:0]  s_tuser_i;     // [1:0] kind, [3:2] op_code
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [39:0] m_tdata_o;     // [31:0] top_value, [38:32] stack_depth, [39] zero
  logic [2:0]  m_tuser_o;     // [2:0] status

  // Predictor state: operand stack and count as the block should hold them.
  logic [31:0]   operand_stack [Depth];
  int            stack_count;
  stack_result_t expected_results [$];

  int error_count;
  int items_sent;
  bit tx_idle_on;             // random gaps on the input side
  bit rx_idle_on;             // random stalls on the result side
  int hold_off_cycles;        // request for one long receiver hold-off

  postfix_stack_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RunLimit);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted item to the stack copy and queues the
  // result the block has to return for it.
  // ---------------------------------------------------------------------------
  task automatic predict_stack_result(input logic [1:0] kind, input logic [31:0] value,
                                      input logic [1:0] op);
    stack_result_t res;
    logic [31:0]   lhs, rhs, outcome, mag_l, mag_r, mag_q;
    bit            finished;
    res.status = pse_pkg::ST_OK;
    finished   = 1'b0;
    outcome    = '0;
    case (kind)
      pse_pkg::KIND_PUSH: begin
        if (stack_count >= Depth) begin
          res.status = pse_pkg::ST_FULL;
        end else begin
          operand_stack[stack_count] = value;
          stack_count++;
        end
      end
      pse_pkg::KIND_OPERATE: begin
        if (stack_count < 2) begin
          res.status = pse_pkg::ST_FEW;
        end else begin
          lhs = operand_stack[stack_count-2];   // second from top
          rhs = operand_stack[stack_count-1];   // top
          case (op)
            pse_pkg::OP_ADD: outcome = lhs + rhs;
            pse_pkg::OP_SUB: outcome = lhs - rhs;
            pse_pkg::OP_MUL: outcome = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                res.status = pse_pkg::ST_DIVZ;
              end else begin
                // Truncating signed divide on magnitudes; min / -1 wraps to min.
                mag_l   = lhs[31] ? -lhs : lhs;
                mag_r   = rhs[31] ? -rhs : rhs;
                mag_q   = mag_l / mag_r;
                outcome = (lhs[31] != rhs[31]) ? -mag_q : mag_q;
              end
            end
          endcase
          if (res.status == pse_pkg::ST_OK) begin
            stack_count--;
            operand_stack[stack_count-1] = outcome;
          end
        end
      end
      pse_pkg::KIND_FINISH: begin
        if (stack_count != 1) begin
          res.status = pse_pkg::ST_FINAL;
        end else begin
          outcome     = operand_stack[0];
          stack_count = 0;
          finished    = 1'b1;
        end
      end
      default: ;  // unused kind: nothing changes, current top is reported
    endcase
    if (finished) res.top = outcome;
    else if (stack_count == 0) res.top = '0;
    else res.top = operand_stack[stack_count-1];
    res.depth = stack_count[6:0];
    expected_results.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    stack_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual status %0d top %h depth %0d",
                 $time, m_tuser_o, m_tdata_o[31:0], m_tdata_o[38:32]);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser_o !== want.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, m_tuser_o);
        end
        if (m_tdata_o[31:0] !== want.top) begin
          error_count++;
          $display("%0t: top_value mismatch, expected %h, actual %h",
                   $time, want.top, m_tdata_o[31:0]);
        end
        if (m_tdata_o[38:32] !== want.depth) begin
          error_count++;
          $display("%0t: stack_depth mismatch, expected %0d, actual %0d",
                   $time, want.depth, m_tdata_o[38:32]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random stall bursts, plus one long hold-off on
  // request so the block backs up and refuses input.
  // ---------------------------------------------------------------------------
  initial begin
    m_tready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        m_tready_i <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
        m_tready_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        m_tready_i <= 1'b1;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. tvalid stays high from one item to the next; it only drops in
  // an idle burst or before a drain, so each step sees a single assignment.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] kind, input logic [31:0] value,
                           input logic [1:0] op);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= value;
    s_tuser_i  <= {op, kind};
    do @(posedge clk_i); while (!s_tready_o);
    predict_stack_result(kind, value, op);
    items_sent++;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= $urandom;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Sender pauses until every outstanding result has come back; it always waits
  // on the clock first so the next item is driven in a later step.
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Random 2-bit kind or operator code.
  function automatic logic [1:0] random_code();
    random_code = 2'($urandom_range(0, 3));
  endfunction

  // Operands biased toward zero, the extremes and small values.
  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0:       random_operand = 32'h0000_0000;
      1:       random_operand = 32'h8000_0000;
      2:       random_operand = 32'h7FFF_FFFF;
      3:       random_operand = 32'hFFFF_FFFF;
      4, 5:    random_operand = $urandom_range(0, 32) - 16;
      default: random_operand = $urandom;
    endcase
  endfunction

  // Reduce whatever sits on the stack to one value and finish it.
  task automatic collapse_stack();
    while (stack_count > 1) send_item(pse_pkg::KIND_OPERATE, $urandom, random_code());
    if (stack_count == 1) send_item(pse_pkg::KIND_FINISH, $urandom, random_code());
  endtask

  // Well-formed expression with random content on top of the current stack.
  task automatic send_expression(input int max_steps);
    send_item(pse_pkg::KIND_PUSH, random_operand(), random_code());
    repeat ($urandom_range(1, max_steps)) begin
      if (stack_count >= 2 && (stack_count >= Depth || $urandom_range(0, 1)))
        send_item(pse_pkg::KIND_OPERATE, $urandom, random_code());
      else
        send_item(pse_pkg::KIND_PUSH, random_operand(), random_code());
    end
    collapse_stack();
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------

  // Empty and one-deep stack: finish and operate errors, then a clean finish.
  task automatic test_empty_stack();
    send_item(pse_pkg::KIND_FINISH, 32'h0, pse_pkg::OP_ADD);       // nothing to report
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_ADD);      // too few operands
    send_item(pse_pkg::KIND_PUSH, 32'd7, pse_pkg::OP_ADD);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_DIV);      // still too few
    send_item(pse_pkg::KIND_FINISH, 32'hFFFF_FFFF, pse_pkg::OP_MUL);
    drain_results();
  endtask

  // 32-bit wrap on add, subtract and multiply.
  task automatic test_wraparound();
    send_item(pse_pkg::KIND_PUSH, 32'h7FFF_FFFF, pse_pkg::OP_ADD);
    send_item(pse_pkg::KIND_PUSH, 32'h0000_0001, pse_pkg::OP_ADD);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_ADD);      // max + 1 -> min
    send_item(pse_pkg::KIND_PUSH, 32'h0000_0001, pse_pkg::OP_SUB);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_SUB);      // min - 1 -> max
    send_item(pse_pkg::KIND_PUSH, 32'h0001_0000, pse_pkg::OP_MUL);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_MUL);      // high bits drop out
    send_item(pse_pkg::KIND_FINISH, 32'h0, pse_pkg::OP_ADD);
    drain_results();
  endtask

  // Truncation toward zero, divide overflow, divide by zero.
  task automatic test_division();
    send_item(pse_pkg::KIND_PUSH, 32'h8000_0000, pse_pkg::OP_DIV);
    send_item(pse_pkg::KIND_PUSH, 32'hFFFF_FFFF, pse_pkg::OP_DIV);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_DIV);      // min / -1 wraps to min
    send_item(pse_pkg::KIND_PUSH, -32'sd7, pse_pkg::OP_DIV);
    send_item(pse_pkg::KIND_PUSH, 32'd2, pse_pkg::OP_DIV);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_DIV);      // -7 / 2 -> -3
    send_item(pse_pkg::KIND_PUSH, 32'd0, pse_pkg::OP_DIV);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_DIV);      // by zero, stack kept
    send_item(pse_pkg::KIND_FINISH, 32'h0, pse_pkg::OP_DIV);       // three left: bad final
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_ADD);
    send_item(pse_pkg::KIND_OPERATE, 32'h0, pse_pkg::OP_SUB);
    send_item(pse_pkg::KIND_FINISH, 32'h0, pse_pkg::OP_DIV);
    drain_results();
  endtask

  // Kind 3 on an empty and on a loaded stack reports the current top only.
  task automatic test_unused_kind();
    send_item(KindUnused, 32'hFFFF_FFFF, pse_pkg::OP_DIV);
    send_item(pse_pkg::KIND_PUSH, 32'h1234_5678, pse_pkg::OP_ADD);
    send_item(KindUnused, 32'h0, pse_pkg::OP_MUL);
    send_item(pse_pkg::KIND_FINISH, 32'h0, pse_pkg::OP_ADD);
    drain_results();
  endtask

  // Fill the stack past its size while the receiver holds off, so the block
  // backs up; then reduce it to one value and finish.
  task automatic test_stack_full();
    hold_off_cycles = LongHold;
    repeat (Depth) send_item(pse_pkg::KIND_PUSH, random_operand(), random_code());
    send_item(pse_pkg::KIND_PUSH, $urandom, random_code());   // stack full
    send_item(KindUnused, $urandom, random_code());
    collapse_stack();
    drain_results();
  endtask

  // Mostly well-formed expressions, some raw noise of any kind.
  task automatic test_random_expressions(input int item_goal);
    while (items_sent < item_goal) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(random_code(), $urandom, random_code());
      end else begin
        send_expression(12);
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    error_count     = 0;
    items_sent      = 0;
    stack_count     = 0;
    hold_off_cycles = 0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    rst_ni     <= 1'b0;
    s_tvalid_i <= 1'b0;
    s_tdata_i  <= '0;
    s_tuser_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_wraparound();
    test_division();
    test_unused_kind();
    test_stack_full();
    test_random_expressions(ItemsRandom);

    // Last stretch runs back to back on both sides.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_expressions(ItemsTotal);

    // Anything that still shows up now is an extra result.
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> postfix_stack_evaluator.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/pse_alu.sv
hw/rtl/postfix_stack_evaluator.sv
hw/rtl/pse_checker.sv
dv/postfix_stack_evaluator_test.sv
